/* rtl/core/udb_pkg.sv */
package udb_pkg;

  // Fixed widths of the register and of the coordinate fields.
  localparam int SIDE_BITS  = 11;
  localparam int COORD_BITS = 10;

  // Side length after reset.
  localparam logic [SIDE_BITS-1:0] SIDE_RESET = 11'd8;

endpackage

/* rtl/core/udb_cell.sv */
module udb_cell
  import udb_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int IDX_BITS   = 10,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  logic                  shift_en,
  input  logic [IDX_BITS-1:0]   entry_idx,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic [VALUE_BITS-1:0] next_value,
  output logic [VALUE_BITS-1:0] value
);

  localparam logic [IDX_BITS-1:0] MyIdx = IDX_BITS'(CELL_IDX);

  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS-1:0] value_nxt;

  // The cell at the entry point takes the new element; every other cell
  // takes the value of its neighbor toward the entry point.
  always_comb begin
    if (entry_idx == MyIdx) begin
      value_nxt = new_value;
    end else begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

/* rtl/core/udb_line.sv */
module udb_line
  import udb_pkg::*;
#(
  parameter int MAX_SIDE   = 1024,
  parameter int VALUE_BITS = 32,
  parameter int IDX_BITS   = 10
) (
  input  logic                  clk,
  input  logic                  shift_en,
  input  logic [IDX_BITS-1:0]   entry_idx,
  input  logic [VALUE_BITS-1:0] new_value,
  output logic [VALUE_BITS-1:0] up_value
);

  // Row of cells. An element enters at the cell that sits at side - 1 and
  // moves one cell toward cell 0 per transfer, so cell 0 holds the element
  // from one row earlier.
  logic [VALUE_BITS-1:0] cell_value [MAX_SIDE];

  for (genvar i = 0; i < MAX_SIDE; i++) begin : g_cell
    logic [VALUE_BITS-1:0] next_value;

    if (i == MAX_SIDE - 1) begin : g_tail
      assign next_value = new_value;
    end else begin : g_body
      assign next_value = cell_value[i+1];
    end

    udb_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX_BITS   (IDX_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk        (clk),
      .shift_en   (shift_en),
      .entry_idx  (entry_idx),
      .new_value  (new_value),
      .next_value (next_value),
      .value      (cell_value[i])
    );
  end

  assign up_value = cell_value[0];

endmodule

/* rtl/core/uniform_2x2_block_detector.sv */
// The result of an element is registered and appears on the output in the
// cycle after the transfer of the element that causes it.
// Throughput: one element per cycle unless a held result is stalled; the line
// buffer is a chain of MAX_SIDE cells that shifts once per element transfer.
// Reset (synchronous, active low) sets the side length to 8, clears the
// counters, the neighbor registers and the valid flag of the output register.
module uniform_2x2_block_detector
  import udb_pkg::*;
#(
  parameter int MAX_SIDE   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [SIDE_BITS-1:0]         cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_element_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COORD_BITS-1:0]        out_match_row,
  output logic [COORD_BITS-1:0]        out_match_col,
  output logic                         out_is_match,
  output logic                         out_frame_end
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int EW = (CW > COORD_BITS) ? CW : COORD_BITS;

  logic [SIDE_BITS-1:0]  side_length_r;
  logic [CW-1:0]         side_m1;
  logic [CW-1:0]         row_r;
  logic [CW-1:0]         row_nxt;
  logic [CW-1:0]         col_r;
  logic [CW-1:0]         col_nxt;
  logic [VALUE_BITS-1:0] left_r;
  logic [VALUE_BITS-1:0] ul_r;
  logic [VALUE_BITS-1:0] cur_value;
  logic [VALUE_BITS-1:0] up_value;
  logic                  in_xfer;
  logic                  match;
  logic                  last;
  logic [EW-1:0]         row_dec;
  logic [EW-1:0]         col_dec;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_row_r;
  logic [COORD_BITS-1:0] out_col_r;
  logic                  out_match_r;
  logic                  out_end_r;

  // The output register takes a new result whenever it is empty or its
  // result leaves in the same cycle.
  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign cur_value = in_element_value;

  // Side length minus one, with zero treated as one and large values
  // saturated to the line buffer length.
  always_comb begin
    if (side_length_r == '0) begin
      side_m1 = '0;
    end else if (32'(side_length_r) > 32'(MAX_SIDE)) begin
      side_m1 = CW'(MAX_SIDE - 1);
    end else begin
      side_m1 = CW'(side_length_r - SIDE_BITS'(1));
    end
  end

  // Line buffer of the previous row.
  udb_line #(
    .MAX_SIDE   (MAX_SIDE),
    .VALUE_BITS (VALUE_BITS),
    .IDX_BITS   (CW)
  ) u_line (
    .clk       (clk),
    .shift_en  (in_xfer),
    .entry_idx (side_m1),
    .new_value (cur_value),
    .up_value  (up_value)
  );

  // Match and frame-end decisions for the current element.
  always_comb begin
    match = (row_r != '0) && (col_r != '0) && (cur_value == left_r) &&
            (cur_value == up_value) && (cur_value == ul_r);
    last  = (row_r == side_m1) && (col_r == side_m1);
    row_dec = EW'(row_r) - EW'(1);
    col_dec = EW'(col_r) - EW'(1);
  end

  // Raster position of the next element.
  always_comb begin
    if (col_r == side_m1) begin
      col_nxt = '0;
      row_nxt = last ? '0 : row_r + CW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  // Configuration, frame position and neighbor registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_length_r <= SIDE_RESET;
      row_r         <= '0;
      col_r         <= '0;
      left_r        <= '0;
      ul_r          <= '0;
    end else begin
      if (cfg_wr_en) begin
        side_length_r <= cfg_wr_data;
        row_r         <= '0;
        col_r         <= '0;
      end else if (in_xfer) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (in_xfer) begin
        left_r <= cur_value;
        ul_r   <= up_value;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= match || last;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_row_r   <= match ? row_dec[COORD_BITS-1:0] : '0;
      out_col_r   <= match ? col_dec[COORD_BITS-1:0] : '0;
      out_match_r <= match;
      out_end_r   <= last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_match_row = out_row_r;
  assign out_match_col = out_col_r;
  assign out_is_match  = out_match_r;
  assign out_frame_end = out_end_r;

`ifndef SYNTH
  // The raster position never leaves the frame.
  a_col_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= side_m1)
    else $error("column counter outside the frame");

  a_row_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= side_m1)
    else $error("row counter outside the frame");

  // Every result is a match or a frame end.
  a_no_empty_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_match || out_frame_end))
    else $error("result with neither match nor frame end");

  // A frame-end element always leaves the position at the frame start.
  a_frame_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && last && !cfg_wr_en) |=> (row_r == '0) && (col_r == '0))
    else $error("frame did not restart after its last element");
`endif

endmodule
